[rtl/core/srdx_pkg.sv]
// Shared types and codes for the serial reply deframer.
// Depends on nothing; used by every module in rtl/core.
`timescale 1ns / 1ps
`default_nettype none
package srdx_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned LEN_W   = 32;
	localparam int unsigned KIND_W  = 3;
	localparam int unsigned HPOS_W  = 3;
	localparam int unsigned CFG_W   = 32;
	localparam int unsigned CFGIX_W = 1;

	localparam logic [CFGIX_W-1:0] REG_EXPECTED_COMMAND = 1'd0;
	localparam logic [CFGIX_W-1:0] REG_EXPECTED_TOTAL   = 1'd1;

	localparam logic [HPOS_W-1:0] HPOS_COMMAND = 3'd4;

	localparam logic [LEN_W-1:0] EXPECTED_TOTAL_RESET = 32'd1;

	typedef enum logic [KIND_W-1:0] {
		KIND_PAYLOAD      = 3'd0,
		KIND_PACKET_OK    = 3'd1,
		KIND_DONE         = 3'd2,
		KIND_BAD_LENGTH   = 3'd3,
		KIND_BAD_COMMAND  = 3'd4,
		KIND_BAD_CHECKSUM = 3'd5
	} kind_t;

	typedef enum logic [3:0] {
		PH_HEADER   = 4'b0001,
		PH_PAYLOAD  = 4'b0010,
		PH_CHECKSUM = 4'b0100,
		PH_ENDED    = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		kind_t             kind;
		logic              last;
	} result_t;

endpackage
`default_nettype wire

[rtl/core/srdx_deframe.sv]
// Framing state and per-byte decision logic: header, payload, checksum.
// Depends on srdx_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srdx_deframe (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            step,
	input  wire  [srdx_pkg::BYTE_W-1:0]    rx_byte,
	input  wire                            start,
	input  wire  [srdx_pkg::BYTE_W-1:0]    expected_command,
	input  wire  [srdx_pkg::LEN_W-1:0]     expected_total,
	output logic                           res_valid,
	output srdx_pkg::result_t              res
);

	srdx_pkg::phase_t              phase_q, ph_e, phase_n;
	logic [srdx_pkg::HPOS_W-1:0]   hpos_q, hp_e, hpos_n;
	logic [srdx_pkg::LEN_W-1:0]    len_q, len_e, len_base, len_n, len_m1;
	logic [srdx_pkg::LEN_W-1:0]    rem_q, rem_n;
	logic [srdx_pkg::LEN_W-1:0]    del_q, del_e, del_n, del_sum;
	logic [srdx_pkg::BYTE_W-1:0]   xor_q, xor_e, xor_base, xor_n;
	logic [srdx_pkg::LEN_W:0]      len_reach;
	logic                          len_bad;

	always_comb begin
		ph_e     = start ? srdx_pkg::PH_HEADER : phase_q;
		hp_e     = start ? '0 : hpos_q;
		len_e    = start ? '0 : len_q;
		del_e    = start ? '0 : del_q;
		xor_e    = start ? '0 : xor_q;
		len_base = (hp_e == '0) ? '0 : len_e;
		xor_base = (hp_e == '0) ? '0 : xor_e;
		len_m1   = len_base - srdx_pkg::LEN_W'(1);
		len_reach = {1'b0, del_e} + {1'b0, len_m1};
		len_bad  = (len_base == '0) || (len_reach > {1'b0, expected_total});
		del_sum  = del_e + (len_e - srdx_pkg::LEN_W'(1));
	end

	always_comb begin
		phase_n   = ph_e;
		hpos_n    = hp_e;
		len_n     = len_e;
		rem_n     = rem_q;
		del_n     = del_e;
		xor_n     = xor_e;
		res_valid = 1'b0;
		res.data  = '0;
		res.kind  = srdx_pkg::KIND_PAYLOAD;
		res.last  = 1'b0;
		case (ph_e)
			srdx_pkg::PH_HEADER: begin
				xor_n = xor_base ^ rx_byte;
				len_n = len_base;
				if (hp_e != srdx_pkg::HPOS_COMMAND) begin
					case (hp_e[1:0])
						2'd0:    len_n[7:0]   = rx_byte;
						2'd1:    len_n[15:8]  = rx_byte;
						2'd2:    len_n[23:16] = rx_byte;
						default: len_n[31:24] = rx_byte;
					endcase
					hpos_n = hp_e + srdx_pkg::HPOS_W'(1);
				end else begin
					hpos_n = '0;
					if (len_bad) begin
						phase_n   = srdx_pkg::PH_ENDED;
						res_valid = 1'b1;
						res.kind  = srdx_pkg::KIND_BAD_LENGTH;
						res.last  = 1'b1;
					end else if (rx_byte != expected_command) begin
						phase_n   = srdx_pkg::PH_ENDED;
						res_valid = 1'b1;
						res.kind  = srdx_pkg::KIND_BAD_COMMAND;
						res.last  = 1'b1;
					end else begin
						rem_n   = len_m1;
						phase_n = (len_m1 != '0) ? srdx_pkg::PH_PAYLOAD
						                        : srdx_pkg::PH_CHECKSUM;
					end
				end
			end
			srdx_pkg::PH_PAYLOAD: begin
				xor_n     = xor_e ^ rx_byte;
				rem_n     = rem_q - srdx_pkg::LEN_W'(1);
				if (rem_n == '0) begin
					phase_n = srdx_pkg::PH_CHECKSUM;
				end
				res_valid = 1'b1;
				res.data  = rx_byte;
			end
			srdx_pkg::PH_CHECKSUM: begin
				res_valid = 1'b1;
				if (rx_byte != xor_e) begin
					phase_n  = srdx_pkg::PH_ENDED;
					res.kind = srdx_pkg::KIND_BAD_CHECKSUM;
					res.last = 1'b1;
				end else begin
					del_n = del_sum;
					if (del_sum >= expected_total) begin
						phase_n  = srdx_pkg::PH_ENDED;
						res.kind = srdx_pkg::KIND_DONE;
						res.last = 1'b1;
					end else begin
						phase_n  = srdx_pkg::PH_HEADER;
						hpos_n   = '0;
						res.kind = srdx_pkg::KIND_PACKET_OK;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= srdx_pkg::PH_HEADER;
			hpos_q  <= '0;
			len_q   <= '0;
			rem_q   <= '0;
			del_q   <= '0;
			xor_q   <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			hpos_q  <= hpos_n;
			len_q   <= len_n;
			rem_q   <= rem_n;
			del_q   <= del_n;
			xor_q   <= xor_n;
		end
	end

endmodule
`default_nettype wire

[rtl/core/srdx_out_reg.sv]
// Result register between the framing logic and the output channel.
// Depends on srdx_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srdx_out_reg (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  load,
	input  srdx_pkg::result_t    res_in,
	input  wire                  out_ready,
	output logic                 out_valid,
	output logic                 out_free,
	output srdx_pkg::result_t    res_q
);

	logic valid_q;

	assign out_valid = valid_q;
	assign out_free  = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule
`default_nettype wire

[rtl/core/serial_reply_deframer_xor.sv]
// Serial reply deframer: length-prefixed packets with an XOR checksum.
// Result path: the input transfer fills the input register, and the result
// register loads from it when the framing state advances.
// Throughput: one byte per cycle while the result register is free (out_free),
// set by the single framing state update per byte. Reset clears framing state
// and output valid; expected_command resets to 0 and expected_total to 1.
// Depends on srdx_pkg, srdx_deframe, srdx_out_reg.
`timescale 1ns / 1ps
`default_nettype none
module serial_reply_deframer_xor (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire  [srdx_pkg::BYTE_W-1:0]       rx_byte,
	input  wire                               start_of_transfer,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic [srdx_pkg::BYTE_W-1:0]       out_byte,
	output logic [srdx_pkg::KIND_W-1:0]       kind,
	output logic                              last,
	input  wire                               cfg_write,
	input  wire  [srdx_pkg::CFGIX_W-1:0]      cfg_index,
	input  wire  [srdx_pkg::CFG_W-1:0]        cfg_data
);

	logic                          valid_s1;
	logic [srdx_pkg::BYTE_W-1:0]   byte_s1;
	logic                          start_s1;
	logic [srdx_pkg::BYTE_W-1:0]   exp_cmd_q;
	logic [srdx_pkg::LEN_W-1:0]    exp_total_q;
	logic                          advance;
	logic                          out_free;
	logic                          res_valid;
	srdx_pkg::result_t             res, res_q;

	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= rx_byte;
			start_s1 <= start_of_transfer;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_cmd_q   <= '0;
			exp_total_q <= srdx_pkg::EXPECTED_TOTAL_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				srdx_pkg::REG_EXPECTED_COMMAND:
					exp_cmd_q <= cfg_data[srdx_pkg::BYTE_W-1:0];
				srdx_pkg::REG_EXPECTED_TOTAL:
					exp_total_q <= cfg_data[srdx_pkg::LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	srdx_deframe u_deframe (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (advance),
		.rx_byte          (byte_s1),
		.start            (start_s1),
		.expected_command (exp_cmd_q),
		.expected_total   (exp_total_q),
		.res_valid        (res_valid),
		.res              (res)
	);

	srdx_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_valid),
		.res_in    (res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_free  (out_free),
		.res_q     (res_q)
	);

	assign out_byte = res_q.data;
	assign kind     = res_q.kind;
	assign last     = res_q.last;

endmodule
`default_nettype wire
